### rtl/core/chd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// chd_pkg: shared constants and types for the compass heading block
// Holds the sample and CORDIC widths, the arctangent table in fractions of a
// turn, the remap constants, the register indexes and the configuration type.
// ============================================================================
package chd_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int FRAC_BITS    = 24;
    // Headroom for the CORDIC gain and the diagonal of a full-scale vector.
    localparam int CORDIC_W     = SAMPLE_BITS + FRAC_BITS + 3;
    localparam int ANGLE_W      = 32;
    localparam int TURN_W       = 16;
    localparam int DEG_W        = 9;
    localparam int DECL_W       = 16;
    localparam int DB_W         = 7;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DECLINATION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND    = 1'd1;

    localparam logic [DECL_W-1:0] DECL_RESET = 16'd200;
    localparam logic [DB_W-1:0]   DB_RESET   = 7'd3;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    localparam logic [DEG_W-1:0] DEG_PER_TURN = 9'd360;
    localparam logic [DEG_W-1:0] REMAP_SPLIT  = 9'd240;
    localparam logic [DEG_W-1:0] REMAP_BASE   = 9'd180;
    localparam logic [7:0]       LOW_SCALE    = 8'd179;
    // ceil(2^24 / 239): exact quotient for every product below 2^16.
    localparam logic [16:0]      RECIP_239    = 17'd70198;
    localparam int               RECIP_SHIFT  = 24;

    typedef logic [DEG_W-1:0] heading_t;

    typedef struct packed {
        logic signed [DECL_W-1:0] declination;
        logic [DB_W-1:0]          deadband;
    } cfg_t;

endpackage

### rtl/core/chd_ifs.sv
`timescale 1ns / 1ps
// ============================================================================
// chd_ifs: request channels of the compass heading block
// A magnetometer sample channel and a heading result channel, each with
// valid, ready and payload, seen from a source and a sink.
// ============================================================================
interface chd_mag_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [chd_pkg::SAMPLE_BITS-1:0] mag_x;
    logic signed [chd_pkg::SAMPLE_BITS-1:0] mag_y;

    modport source (output valid, output mag_x, output mag_y, input ready);
    modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

interface chd_heading_if;
    logic                      valid;
    logic                      ready;
    logic [chd_pkg::DEG_W-1:0] heading_deg;
    logic                      held;

    modport source (output valid, output heading_deg, output held, input ready);
    modport sink   (input valid, input heading_deg, input held, output ready);
endinterface

### rtl/core/chd_front.sv
`timescale 1ns / 1ps
// ============================================================================
// chd_front: CORDIC angle pipeline and degree remap
// Pre-rotates each sample into the right half plane, runs one vectoring
// CORDIC iteration per stage, adds the declination, scales to degrees and
// applies the piecewise remap. The whole pipe advances on one enable.
// ============================================================================
module chd_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [chd_pkg::SAMPLE_BITS-1:0] mag_x,
    input  logic signed [chd_pkg::SAMPLE_BITS-1:0] mag_y,
    input  chd_pkg::cfg_t                        cfg,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output chd_pkg::heading_t                    out_heading
);

    localparam int W    = chd_pkg::CORDIC_W;
    localparam int N    = chd_pkg::CORDIC_STEPS;
    localparam int EXTW = W - chd_pkg::SAMPLE_BITS - chd_pkg::FRAC_BITS;

    logic advance;

    logic                             vld_reg [0:N];
    logic signed [W-1:0]              x_reg   [0:N];
    logic signed [W-1:0]              y_reg   [0:N];
    logic [chd_pkg::ANGLE_W-1:0]      a_reg   [0:N];
    logic                             zero_reg [0:N];

    logic signed [W-1:0] x_ext;
    logic signed [W-1:0] y_ext;
    logic                flip;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    assign x_ext = {{EXTW{mag_x[chd_pkg::SAMPLE_BITS-1]}}, mag_x, {chd_pkg::FRAC_BITS{1'b0}}};
    assign y_ext = {{EXTW{mag_y[chd_pkg::SAMPLE_BITS-1]}}, mag_y, {chd_pkg::FRAC_BITS{1'b0}}};
    assign flip  = mag_x[chd_pkg::SAMPLE_BITS-1];

    // Entry stage: rotate by half a turn when x is negative.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]    <= flip ? -x_ext : x_ext;
            y_reg[0]    <= flip ? -y_ext : y_ext;
            a_reg[0]    <= flip ? chd_pkg::HALF_TURN : '0;
            zero_reg[0] <= (mag_x == '0) && (mag_y == '0);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= N; k++)
        begin : g_iter
            logic signed [W-1:0] xs;
            logic signed [W-1:0] ys;
            logic                pos;

            assign xs  = x_reg[k-1] >>> (k - 1);
            assign ys  = y_reg[k-1] >>> (k - 1);
            assign pos = !y_reg[k-1][W-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (advance)
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    x_reg[k]    <= pos ? x_reg[k-1] + ys : x_reg[k-1] - ys;
                    y_reg[k]    <= pos ? y_reg[k-1] - xs : y_reg[k-1] + xs;
                    a_reg[k]    <= pos ? a_reg[k-1] + chd_pkg::ATAN_TURNS[k-1]
                                       : a_reg[k-1] - chd_pkg::ATAN_TURNS[k-1];
                    zero_reg[k] <= zero_reg[k-1];
                end
            end
        end
    endgenerate

    // Post stages: degrees, low-branch product, remapped value.
    logic [chd_pkg::TURN_W-1:0] a16;
    logic [chd_pkg::TURN_W-1:0] turn;
    logic [24:0]                deg_prod;
    logic                       deg_vld_reg;
    logic [chd_pkg::DEG_W-1:0]  deg_reg;
    logic                       prod_vld_reg;
    logic [chd_pkg::DEG_W-1:0]  deg2_reg;
    logic [15:0]                low_prod_reg;
    logic                       rmp_vld_reg;
    chd_pkg::heading_t          rmp_reg;

    logic [32:0]                recip_prod;
    logic [6:0]                 high_off;
    logic [8:0]                 high_x3;
    chd_pkg::heading_t          rmp_next;

    assign a16      = zero_reg[N] ? '0 : a_reg[N][chd_pkg::ANGLE_W-1 -: chd_pkg::TURN_W];
    assign turn     = a16 + chd_pkg::TURN_W'(cfg.declination);
    assign deg_prod = {9'd0, turn} * {16'd0, chd_pkg::DEG_PER_TURN};

    assign recip_prod = {17'd0, low_prod_reg} * {16'd0, chd_pkg::RECIP_239};
    assign high_off   = 7'(deg2_reg - chd_pkg::REMAP_SPLIT);
    assign high_x3    = {1'b0, high_off, 1'b0} + {2'b00, high_off};

    always_comb
    begin
        if (deg2_reg >= chd_pkg::REMAP_SPLIT)
        begin
            rmp_next = chd_pkg::REMAP_BASE + {1'b0, high_x3[8:1]};
        end
        else
        begin
            rmp_next = recip_prod[chd_pkg::RECIP_SHIFT +: chd_pkg::DEG_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            rmp_vld_reg  <= 1'b0;
        end
        else if (advance)
        begin
            deg_vld_reg  <= vld_reg[N];
            prod_vld_reg <= deg_vld_reg;
            rmp_vld_reg  <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            deg_reg      <= deg_prod[24:16];
            deg2_reg     <= deg_reg;
            low_prod_reg <= {7'd0, deg_reg} * {8'd0, chd_pkg::LOW_SCALE};
            rmp_reg      <= rmp_next;
        end
    end

    assign out_valid   = rmp_vld_reg;
    assign out_heading = rmp_reg;

endmodule

### rtl/core/chd_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// chd_queue: two-entry queue between the angle pipe and the deadband
// Lets the front keep streaming while the back end waits on its receiver.
// ============================================================================
module chd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  chd_pkg::heading_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output chd_pkg::heading_t pop_data
);

    chd_pkg::heading_t data_reg [0:1];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = data_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/core/chd_back.sv
`timescale 1ns / 1ps
// ============================================================================
// chd_back: deadband against the previous heading and output register
// Holds the previous heading when the new one lies strictly inside the band
// and presents each result in a register until the receiver takes it.
// ============================================================================
module chd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  chd_pkg::heading_t in_heading,
    input  logic [chd_pkg::DB_W-1:0] deadband,
    output logic              out_valid,
    input  logic              out_ready,
    output chd_pkg::heading_t out_heading,
    output logic              out_held
);

    localparam int SW = chd_pkg::DEG_W + 1;

    logic              out_valid_reg;
    chd_pkg::heading_t heading_reg;
    logic              held_reg;
    chd_pkg::heading_t prev_reg;
    logic              load;
    logic [SW-1:0]     n_plus_db;
    logic [SW-1:0]     p_plus_db;
    logic              in_band;

    assign in_ready  = !out_valid_reg || out_ready;
    assign load      = in_valid && in_ready;

    // p - db < n < p + db, kept non-negative by moving db to the other side.
    assign n_plus_db = {1'b0, in_heading} + SW'(deadband);
    assign p_plus_db = {1'b0, prev_reg} + SW'(deadband);
    assign in_band   = (n_plus_db > {1'b0, prev_reg}) && ({1'b0, in_heading} < p_plus_db);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                prev_reg      <= in_band ? prev_reg : in_heading;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            heading_reg <= in_band ? prev_reg : in_heading;
            held_reg    <= in_band;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_heading = heading_reg;
    assign out_held    = held_reg;

`ifndef NO_ASSERTIONS
    a_held_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (!held_reg || heading_reg == $past(prev_reg)))
        else $error("held result differs from previous heading");

    a_zero_band: assert property (@(posedge clk) disable iff (!rst_n)
        (load && deadband == '0) |=> !held_reg)
        else $error("result held with zero deadband");
`endif

endmodule

### rtl/core/compass_heading_deadband.sv
`timescale 1ns / 1ps
// ============================================================================
// compass_heading_deadband: magnetometer sample to smoothed compass heading
// Top level: configuration registers, angle pipe, queue and deadband stage.
// ============================================================================
// Usage:
// A sample request on the mag channel carries signed X and Y readings. Each
// accepted request yields exactly one request on the heading channel with
// the remapped heading in whole degrees and a flag that says whether the
// deadband held the previous heading.
// From acceptance to valid on the heading channel, a sample passes one
// entry stage, one stage per CORDIC iteration (16), three stages for the
// declination with degree scaling, the low-branch product and the remap,
// the queue and the output register. Throughput is one sample per cycle
// while the receiver keeps up: the previous-heading compare is combinational.
// When the receiver stalls, the output register holds its result, the
// two-entry queue fills, and then the whole angle pipe freezes and mag.ready
// drops; nothing is lost or repeated.
// Reset clears all valid flags and sets the previous heading to 0, the
// declination to 200/65536 turn and the deadband to 3 degrees.
// Configuration writes take effect at once and are meant for idle periods.
// ============================================================================
module compass_heading_deadband (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [chd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [chd_pkg::CFG_DATA_W-1:0]     cfg_data,
    chd_mag_if.sink                            mag,
    chd_heading_if.source                      heading
);

    chd_pkg::cfg_t     cfg_reg;

    logic              front_valid;
    logic              front_ready;
    chd_pkg::heading_t front_heading;
    logic              queue_valid;
    logic              queue_ready;
    chd_pkg::heading_t queue_heading;

    // Configuration registers, written by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.declination <= chd_pkg::DECL_RESET;
            cfg_reg.deadband    <= chd_pkg::DB_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                chd_pkg::REG_DECLINATION:
                begin
                    cfg_reg.declination <= cfg_data[chd_pkg::DECL_W-1:0];
                end
                chd_pkg::REG_DEADBAND:
                begin
                    cfg_reg.deadband <= cfg_data[chd_pkg::DB_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Front: CORDIC angle, declination, degrees and remap.
    chd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (mag.valid),
        .in_ready    (mag.ready),
        .mag_x       (mag.mag_x),
        .mag_y       (mag.mag_y),
        .cfg         (cfg_reg),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_heading (front_heading)
    );

    // The queue decouples the pipe from the deadband stage.
    chd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_heading),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_heading)
    );

    // Back: deadband and the registered result.
    chd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (queue_valid),
        .in_ready    (queue_ready),
        .in_heading  (queue_heading),
        .deadband    (cfg_reg.deadband),
        .out_valid   (heading.valid),
        .out_ready   (heading.ready),
        .out_heading (heading.heading_deg),
        .out_held    (heading.held)
    );

endmodule
